>>> rtl/ght_pkg.sv
// shared types, constants and the free-slot search for the handle table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

    localparam int unsigned SLOT_COUNT = 64;
    localparam int unsigned IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned HIDX_W     = 16;
    localparam int unsigned GEN_W      = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned TYPE_W     = 8;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLOSE  = 2'd2;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_PERM    = 2'd2;
    localparam logic [1:0] STS_FULL    = 2'd3;

    localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

    typedef struct packed {
        logic [GEN_W-1:0]  generation;
        logic [WORD_W-1:0] object_word;
        logic [TYPE_W-1:0] object_type;
        logic [WORD_W-1:0] rights;
    } t_slot;

    localparam t_slot SLOT_RESET = '{
        generation:  GEN_FIRST,
        object_word: '0,
        object_type: '0,
        rights:      '0
    };

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_slot            data;
    } t_wr;

    typedef struct packed {
        logic             any;
        logic [IDX_W-1:0] idx;
    } t_free;

    function automatic t_free find_free(input logic [SLOT_COUNT-1:0] used);
        t_free res;
        res.any = 1'b0;
        res.idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!used[i]) begin
                res.any = 1'b1;
                res.idx = IDX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ght_slot_store.sv
// slot record memory with registered read and per-entry written bits
// depends on ght_pkg; unwritten entries read as the reset record
`timescale 1ns / 1ps
`default_nettype none

module ght_slot_store (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ght_pkg::t_rd  i_rd,
    input  wire ght_pkg::t_wr  i_wr,
    output ght_pkg::t_slot     o_rd_data
);
    import ght_pkg::*;

    t_slot                 r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_init;
    t_slot                 r_rd_data;
    logic                  r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_init[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_init <= r_init[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_init ? r_rd_data : SLOT_RESET;

endmodule

`default_nettype wire

>>> rtl/generational_handle_table.sv
// generational handle table top level: command decode, used bits, slot checks
// depends on ght_pkg and ght_slot_store
`timescale 1ns / 1ps
`default_nettype none

// Each command has a read step and an execute step: the cycle in which start is taken
// reads the slot record from the slot memory (separate read and write ports), the next
// cycle checks it, writes it back and registers the result, so busy is high for one
// cycle after each accepted command and o_done pulses in the cycle after that, when the
// next command may already be taken. Results cannot be stalled; o_done marks each
// result beat for exactly one cycle. The lowest free slot for alloc is kept ready in a
// register updated from the used bits. No clearing pass is needed after reset.
module generational_handle_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_handle_in,
    input  wire logic [31:0] i_object_word,
    input  wire logic [7:0]  i_object_type,
    input  wire logic [31:0] i_rights_mask,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [31:0]      o_handle_out,
    output logic [31:0]      o_object_out
);
    import ght_pkg::*;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                r_state;
    logic [SLOT_COUNT-1:0] r_used;
    logic [SLOT_COUNT-1:0] n_used;
    t_free                 r_free;
    t_free                 n_free;

    logic [1:0]            r_cmd;
    logic [GEN_W-1:0]      r_gen_in;
    logic                  r_in_range;
    logic [IDX_W-1:0]      r_idx;
    logic [WORD_W-1:0]     r_obj;
    logic [TYPE_W-1:0]     r_type;
    logic [WORD_W-1:0]     r_rights;

    logic                  r_done;
    logic [1:0]            r_status;
    logic [31:0]           r_handle_out;
    logic [31:0]           r_object_out;

    logic                  accept;
    logic                  in_range;
    logic [IDX_W-1:0]      n_idx;
    t_rd                   rd;
    t_wr                   wr;
    t_slot                 slot;
    logic                  resolve_ok;
    logic [GEN_W-1:0]      gen_inc;
    logic [GEN_W-1:0]      gen_next;
    logic [1:0]            n_status;
    logic [31:0]           n_handle_out;
    logic [31:0]           n_object_out;

    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;

    assign in_range = {1'b0, i_handle_in[HIDX_W-1:0]} < (HIDX_W + 1)'(SLOT_COUNT);
    assign n_idx    = (i_command == CMD_ALLOC) ? r_free.idx : i_handle_in[IDX_W-1:0];

    assign rd.en   = accept;
    assign rd.addr = n_idx;

    ght_slot_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (rd),
        .i_wr     (wr),
        .o_rd_data(slot)
    );

    assign resolve_ok = r_in_range && r_used[r_idx] && (slot.generation == r_gen_in);
    assign gen_inc    = slot.generation + GEN_W'(1);
    assign gen_next   = (gen_inc == '0) ? GEN_FIRST : gen_inc;

    always_comb begin
        n_used       = r_used;
        n_status     = STS_INVALID;
        n_handle_out = '0;
        n_object_out = '0;
        wr.en        = 1'b0;
        wr.addr      = r_idx;
        wr.data      = SLOT_RESET;
        if (r_state == S_EXEC) begin
            case (r_cmd)
                CMD_ALLOC: begin
                    if (r_obj != '0 && r_type != '0) begin
                        if (r_free.any) begin
                            wr.en                  = 1'b1;
                            wr.data.generation     = slot.generation;
                            wr.data.object_word    = r_obj;
                            wr.data.object_type    = r_type;
                            wr.data.rights         = r_rights;
                            n_used[r_idx]          = 1'b1;
                            n_status               = STS_OK;
                            n_handle_out           = {slot.generation, HIDX_W'(r_idx)};
                        end else begin
                            n_status = STS_FULL;
                        end
                    end
                end
                CMD_LOOKUP: begin
                    if (resolve_ok) begin
                        if (r_type != '0 && slot.object_type != r_type) begin
                            n_status = STS_INVALID;
                        end else if ((slot.rights & r_rights) != r_rights) begin
                            n_status = STS_PERM;
                        end else begin
                            n_status     = STS_OK;
                            n_object_out = slot.object_word;
                        end
                    end
                end
                CMD_CLOSE: begin
                    if (resolve_ok) begin
                        wr.en              = 1'b1;
                        wr.data.generation = gen_next;
                        n_used[r_idx]      = 1'b0;
                        n_status           = STS_OK;
                    end
                end
                default: begin
                    n_status = STS_INVALID;
                end
            endcase
        end
    end

    assign n_free = find_free(n_used);

    // command fields of the beat in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_command;
            r_gen_in   <= i_handle_in[31:HIDX_W];
            r_in_range <= in_range;
            r_idx      <= n_idx;
            r_obj      <= i_object_word;
            r_type     <= i_object_type;
            r_rights   <= i_rights_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_free       <= find_free('0);
            r_done       <= 1'b0;
            r_status     <= STS_OK;
            r_handle_out <= '0;
            r_object_out <= '0;
        end else begin
            r_used <= n_used;
            r_free <= n_free;
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state      <= S_IDLE;
                    r_done       <= 1'b1;
                    r_status     <= n_status;
                    r_handle_out <= n_handle_out;
                    r_object_out <= n_object_out;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_handle_out = r_handle_out;
    assign o_object_out = r_object_out;

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result beat without a preceding execute cycle");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_alloc_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STS_OK && r_cmd == CMD_ALLOC)
            |-> r_used[o_handle_out[IDX_W-1:0]])
        else $error("allocated slot not marked used");

    a_fail_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != STS_OK) |-> (o_handle_out == '0 && o_object_out == '0))
        else $error("failed command returned non-zero payload");
`endif

endmodule

`default_nettype wire

>>> tb/handle_table_checker.sv
// checker for the generational handle table: predicts each reply from its own slot table
// and compares it with the reply beats seen on the result ports
// depends on ght_pkg
`timescale 1ns / 1ps

module handle_table_checker
    import ght_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_handle_in,
    input  wire logic [31:0] i_object_word,
    input  wire logic [7:0]  i_object_type,
    input  wire logic [31:0] i_rights_mask,
    input  wire logic        o_done,
    input  wire logic [1:0]  o_status,
    input  wire logic [31:0] o_handle_out,
    input  wire logic [31:0] o_object_out,
    output int               mismatch_count,
    output int               replies_owed
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle;
        logic [31:0] object_word;
    } t_reply;

    logic        used_q   [SLOT_COUNT];
    logic [15:0] gen_q    [SLOT_COUNT];
    logic [31:0] object_q [SLOT_COUNT];
    logic [7:0]  type_q   [SLOT_COUNT];
    logic [31:0] rights_q [SLOT_COUNT];

    t_reply owed_replies [$];
    t_reply want;
    t_reply got;

    function automatic bit handle_names_live_slot(input logic [31:0] hdl);
        if (hdl == '0 || hdl[15:0] >= SLOT_COUNT) return 1'b0;
        if (!used_q[hdl[15:0]]) return 1'b0;
        return gen_q[hdl[15:0]] == hdl[31:16];
    endfunction

    function automatic t_reply predict_reply(
        input logic [1:0]  cmd,
        input logic [31:0] hdl,
        input logic [31:0] obj,
        input logic [7:0]  typ,
        input logic [31:0] rts
    );
        t_reply r;
        int idx;
        bit found;
        logic [15:0] nxt;
        r = '{status: STS_INVALID, handle: '0, object_word: '0};
        found = 1'b0;
        case (cmd)
            CMD_ALLOC: begin
                if (obj != '0 && typ != '0) begin
                    r.status = STS_FULL;
                    for (idx = 0; idx < SLOT_COUNT; idx++) begin
                        if (!found && !used_q[idx]) begin
                            found         = 1'b1;
                            used_q[idx]   = 1'b1;
                            object_q[idx] = obj;
                            type_q[idx]   = typ;
                            rights_q[idx] = rts;
                            r.handle      = {gen_q[idx], 16'(idx)};
                            r.status      = STS_OK;
                        end
                    end
                end
            end
            CMD_LOOKUP: begin
                if (handle_names_live_slot(hdl)) begin
                    idx = int'(hdl[15:0]);
                    if (typ != '0 && type_q[idx] != typ) begin
                        r.status = STS_INVALID;
                    end else if ((rights_q[idx] & rts) != rts) begin
                        r.status = STS_PERM;
                    end else begin
                        r.status      = STS_OK;
                        r.object_word = object_q[idx];
                    end
                end
            end
            CMD_CLOSE: begin
                if (handle_names_live_slot(hdl)) begin
                    idx           = int'(hdl[15:0]);
                    nxt           = gen_q[idx] + 16'd1;
                    used_q[idx]   = 1'b0;
                    object_q[idx] = '0;
                    type_q[idx]   = '0;
                    rights_q[idx] = '0;
                    gen_q[idx]    = (nxt == '0) ? GEN_FIRST : nxt;
                    r.status      = STS_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        mismatch_count = 0;
        replies_owed   = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                used_q[s]   = 1'b0;
                gen_q[s]    = GEN_FIRST;
                object_q[s] = '0;
                type_q[s]   = '0;
                rights_q[s] = '0;
            end
            owed_replies.delete();
        end else begin
            // the reply beat seen here belongs to an earlier command, so check before predicting
            if (o_done) begin
                got = '{status: o_status, handle: o_handle_out, object_word: o_object_out};
                if (owed_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: reply beat with none owed: status %0d handle %h object %h",
                                 $time, got.status, got.handle, got.object_word);
                end else begin
                    want = owed_replies.pop_front();
                    if (got.status !== want.status || got.handle !== want.handle ||
                        got.object_word !== want.object_word) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display(
                                "%0t: mismatch exp/got: status %0d/%0d handle %h/%h object %h/%h",
                                $time, want.status, got.status, want.handle, got.handle,
                                want.object_word, got.object_word);
                    end
                end
            end
            if (start && !busy)
                owed_replies.push_back(predict_reply(i_command, i_handle_in, i_object_word,
                                                     i_object_type, i_rights_mask));
        end
        replies_owed = owed_replies.size();
    end

endmodule

>>> tb/tb_top.sv
// top of the handle table testbench: clock, reset, command stimulus and the verdict
// depends on ght_pkg, generational_handle_table and handle_table_checker
`timescale 1ns / 1ps

module tb_top;
    import ght_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         RANDOM_ITEMS   = 1000;
    localparam int         WATCHDOG_LIMIT = 1000;

    typedef struct {
        logic [31:0] handle;
        logic [7:0]  object_type;
        logic [31:0] rights;
    } t_grant;

    typedef struct {
        logic [1:0]  command;
        logic [7:0]  object_type;
        logic [31:0] rights;
    } t_sent;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [31:0] i_handle_in;
    logic [31:0] i_object_word;
    logic [7:0]  i_object_type;
    logic [31:0] i_rights_mask;
    logic        o_done;
    logic [1:0]  o_status;
    logic [31:0] o_handle_out;
    logic [31:0] o_object_out;

    int mismatch_count;
    int replies_owed;
    int quiet_cycles;
    int commands_sent;
    int replies_seen;

    t_grant      grants   [$];
    t_sent       sent_log [$];
    t_sent       sent;
    logic [31:0] last_grant;

    generational_handle_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_handle_in   (i_handle_in),
        .i_object_word (i_object_word),
        .i_object_type (i_object_type),
        .i_rights_mask (i_rights_mask),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_handle_out  (o_handle_out),
        .o_object_out  (o_object_out)
    );

    handle_table_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_handle_in    (i_handle_in),
        .i_object_word  (i_object_word),
        .i_object_type  (i_object_type),
        .i_rights_mask  (i_rights_mask),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_handle_out   (o_handle_out),
        .o_object_out   (o_object_out),
        .mismatch_count (mismatch_count),
        .replies_owed   (replies_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // granted handles feed later lookups and closes
    always @(posedge i_clk) begin
        if (i_rst_n && o_done && sent_log.size() != 0) begin
            sent = sent_log.pop_front();
            if (sent.command == CMD_ALLOC && o_status == STS_OK) begin
                last_grant = o_handle_out;
                grants.push_back('{o_handle_out, sent.object_type, sent.rights});
            end
            replies_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic issue(
        input logic [1:0]  cmd,
        input logic [31:0] hdl,
        input logic [31:0] obj,
        input logic [7:0]  typ,
        input logic [31:0] rts
    );
        start         <= 1'b1;
        i_command     <= cmd;
        i_handle_in   <= hdl;
        i_object_word <= obj;
        i_object_type <= typ;
        i_rights_mask <= rts;
        do @(posedge i_clk); while (busy);
        commands_sent++;
        sent_log.push_back('{cmd, typ, rts});
        if (cmd == CMD_CLOSE) begin
            for (int k = grants.size() - 1; k >= 0; k--)
                if (grants[k].handle == hdl) grants.delete(k);
        end
    endtask

    task automatic pause();
        start         <= 1'b0;
        i_command     <= 2'($urandom);
        i_handle_in   <= $urandom;
        i_object_word <= $urandom;
        i_object_type <= 8'($urandom);
        i_rights_mask <= $urandom;
        @(posedge i_clk);
    endtask

    task automatic wait_replies();
        start <= 1'b0;
        while (replies_seen != commands_sent) @(posedge i_clk);
    endtask

    task automatic random_item(input bit filling);
        int unsigned roll;
        int unsigned pick;
        logic [1:0]  cmd;
        logic [31:0] hdl;
        logic [31:0] obj;
        logic [31:0] rts;
        logic [7:0]  typ;
        t_grant      g;
        roll = $urandom_range(99);
        obj  = $urandom;
        typ  = 8'($urandom);
        rts  = $urandom;
        if ($urandom_range(1))
            hdl = $urandom;
        else
            hdl = {16'($urandom_range(4)), 16'($urandom_range(SLOT_COUNT - 1))};
        if (roll < 3) begin
            cmd = CMD_UNUSED;
        end else if (roll < (filling ? 68 : 18)) begin
            cmd = CMD_ALLOC;
            if ($urandom_range(19) == 0) obj = '0;
            if ($urandom_range(19) == 0) typ = '0;
        end else begin
            cmd = (roll < (filling ? 88 : 48)) ? CMD_LOOKUP : CMD_CLOSE;
            if (grants.size() != 0 && $urandom_range(9) != 0) begin
                g   = grants[$urandom_range(grants.size() - 1)];
                hdl = g.handle;
                case ($urandom_range(19))
                    0:       hdl[31:16] = 16'($urandom);
                    1:       hdl[15:0]  = 16'($urandom_range(65535, SLOT_COUNT));
                    2:       hdl        = '0;
                    default: ;
                endcase
                pick = $urandom_range(9);
                if (pick < 4) typ = '0;
                else if (pick < 8) typ = g.object_type;
                pick = $urandom_range(9);
                if (pick < 4) rts = '0;
                else if (pick < 7) rts = g.rights & $urandom;
                else if (pick < 9) rts = g.rights | (32'd1 << $urandom_range(31));
            end else begin
                if ($urandom_range(1)) typ = '0;
                if ($urandom_range(1)) rts = '0;
            end
        end
        issue(cmd, hdl, obj, typ, rts);
    endtask

    initial begin
        logic [31:0] hdl;
        bit          steady;
        start         = 1'b0;
        i_rst_n       = 1'b0;
        i_command     = '0;
        i_handle_in   = '0;
        i_object_word = '0;
        i_object_type = '0;
        i_rights_mask = '0;
        quiet_cycles  = 0;
        commands_sent = 0;
        replies_seen  = 0;
        last_grant    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner cases on a fresh table
        issue(CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0);
        issue(CMD_CLOSE, 32'h0, 32'h0, 8'h00, 32'h0);
        issue(CMD_ALLOC, 32'h0, 32'h0, 8'h05, 32'h1);
        issue(CMD_ALLOC, 32'h0, 32'h1234, 8'h00, 32'h1);
        issue(CMD_ALLOC, 32'h0, 32'hffff_ffff, 8'hff, 32'hffff_ffff);
        issue(CMD_ALLOC, 32'h0, 32'h1, 8'h01, 32'h0);
        issue(CMD_LOOKUP, 32'h0001_0000, 32'h0, 8'h00, 32'h0);
        issue(CMD_LOOKUP, 32'h0001_0000, 32'h0, 8'hff, 32'hffff_ffff);
        issue(CMD_LOOKUP, 32'h0001_0001, 32'h0, 8'h01, 32'h1);
        issue(CMD_LOOKUP, 32'h0001_0001, 32'h0, 8'h02, 32'h0);
        issue(CMD_LOOKUP, 32'h0002_0000, 32'h0, 8'h00, 32'h0);
        issue(CMD_LOOKUP, 32'h0001_0040, 32'h0, 8'h00, 32'h0);
        issue(CMD_LOOKUP, 32'h0001_ffff, 32'h0, 8'h00, 32'h0);
        issue(CMD_LOOKUP, 32'h0001_0002, 32'h0, 8'h00, 32'h0);
        issue(CMD_UNUSED, 32'h0001_0000, 32'hffff_ffff, 8'hff, 32'hffff_ffff);
        issue(CMD_CLOSE, 32'h0001_0000, 32'h0, 8'h00, 32'h0);
        issue(CMD_LOOKUP, 32'h0001_0000, 32'h0, 8'h00, 32'h0);
        issue(CMD_CLOSE, 32'h0001_0000, 32'h0, 8'h00, 32'h0);
        issue(CMD_ALLOC, 32'h0, 32'h8000_0000, 8'h80, 32'h8000_0000);
        issue(CMD_LOOKUP, 32'h0002_0000, 32'h0, 8'h80, 32'h8000_0000);
        issue(CMD_CLOSE, 32'h0002_0000, 32'h0, 8'h00, 32'h0);

        // cycle one slot through a few generations
        issue(CMD_ALLOC, 32'h0, 32'h5a5a_0001, 8'h42, 32'h0000_00ff);
        wait_replies();
        hdl = last_grant;
        for (int n = 0; n < 8; n++) begin
            issue(CMD_CLOSE, hdl, 32'h0, 8'h00, 32'h0);
            issue(CMD_ALLOC, 32'h0, 32'h5a5a_0001, 8'h42, 32'h0000_00ff);
            wait_replies();
            hdl = last_grant;
        end
        issue(CMD_LOOKUP, hdl, 32'h0, 8'h42, 32'h0000_00ff);
        issue(CMD_LOOKUP, {16'hffff, hdl[15:0]}, 32'h0, 8'h00, 32'h0);
        issue(CMD_LOOKUP, {16'h0000, hdl[15:0]}, 32'h0, 8'h00, 32'h0);
        issue(CMD_CLOSE, hdl, 32'h0, 8'h00, 32'h0);

        // alternating fill and drain epochs, one of them without gaps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 300 && n < 450);
            while (!steady && $urandom_range(99) < 31) pause();
            random_item(((n / 150) % 2) == 0);
        end
        start <= 1'b0;

        while (replies_owed != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/ght_pkg.sv
rtl/ght_slot_store.sv
rtl/generational_handle_table.sv
tb/handle_table_checker.sv
tb/tb_top.sv
